/* rtl/pis_pkg.sv */
// Shared types, constants and the arctangent table of the point-in-sector test.
package pis_pkg;

	// Default parameter values for the top level.
	localparam int ANGLE_BITS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	// Number of entries in the arctangent table, and so the most rotation steps.
	localparam int ATAN_LEN = 24;

	// Widths of the normalized vector, the magnitude word and the rotator datapath.
	localparam int NW = 41;
	localparam int MW = 40;
	localparam int CW = 44;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X = 3'd0,
		CFG_CENTER_Y = 3'd1,
		CFG_HEADING  = 3'd2,
		CFG_REACH    = 3'd3,
		CFG_SPAN     = 3'd4
	} cfg_idx_t;

	// Register reset values: radius 5.0 m, opening of a quarter turn.
	localparam logic [30:0] REACH_RST = 31'd327680;
	localparam logic [15:0] SPAN_RST  = 16'd16384;

	// Angles in units of 2^-32 turn.
	localparam logic [31:0] TURN_ZERO    = 32'h0000_0000;
	localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
	localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
	localparam logic [31:0] TURN_3Q      = 32'hC000_0000;

	// atan(2^-i) in units of 2^-32 turn, rounded.
	localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// Vector on its way through normalization; w is the OR of both magnitudes.
	typedef struct packed {
		logic signed [NW-1:0] x;
		logic signed [NW-1:0] y;
		logic [MW-1:0]        w;
	} norm_t;

	// Word handed from cell to cell in the rotator chain.
	typedef struct packed {
		logic                 hold;
		logic                 near;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [31:0]          z;
	} rot_t;

endpackage

/* rtl/pis_pt_if.sv */
// Point channel: valid/ready handshake carrying one point word.
interface pis_pt_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

/* rtl/pis_res_if.sv */
// Result channel: valid/ready handshake carrying one test result word.
interface pis_res_if;
	logic        valid;
	logic        ready;
	logic        inside_res;
	logic        within_reach;
	logic [15:0] bearing;

	modport source (output valid, output inside_res, output within_reach, output bearing,
		input ready);
	modport sink   (input valid, input inside_res, input within_reach, input bearing,
		output ready);
endinterface

/* rtl/pis_norm.sv */
// Normalizer stage: three conditional left shifts that bring the larger magnitude up.
module pis_norm #(
	parameter int unsigned SH0 = 32
) (
	input  logic             clk,
	input  logic             en,
	input  pis_pkg::norm_t   d,
	output pis_pkg::norm_t   q
);

	pis_pkg::norm_t t;

	// Shift by SH0, SH0/2 and SH0/4 wherever the top bits of the magnitude word are clear.
	always_comb begin
		int unsigned sh;
		t = d;
		for (int k = 0; k < 3; k++) begin
			sh = SH0 >> k;
			if ((t.w >> (pis_pkg::MW - sh)) == '0) begin
				t.w = t.w << sh;
				t.x = t.x <<< sh;
				t.y = t.y <<< sh;
			end
		end
	end

	// Stage register.
	always_ff @(posedge clk) begin
		if (en) begin
			q <= t;
		end
	end

endmodule

/* rtl/pis_cell.sv */
// One CORDIC vectoring cell: a single micro-rotation toward the x axis.
module pis_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic           clk,
	input  logic           en,
	input  pis_pkg::rot_t  d,
	output pis_pkg::rot_t  q
);

	pis_pkg::rot_t nxt;

	// Rotate by atan(2^-IDX) against the sign of y; axis points pass untouched.
	always_comb begin
		nxt = d;
		if (!d.hold) begin
			if (d.y[pis_pkg::CW-1]) begin
				nxt.x = d.x - (d.y >>> IDX);
				nxt.y = d.y + (d.x >>> IDX);
				nxt.z = d.z - pis_pkg::ATAN_TURNS[IDX];
			end else begin
				nxt.x = d.x + (d.y >>> IDX);
				nxt.y = d.y - (d.x >>> IDX);
				nxt.z = d.z + pis_pkg::ATAN_TURNS[IDX];
			end
		end
	end

	// Cell register.
	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

/* rtl/point_in_sector_test.sv */
// Top level of the point-in-sector test: distance check, bearing chain and sector compare.
// The block takes one point per clock unless a stalled result holds the chain, and returns one
// result word for each point, in order. The edge that accepts a point loads its offset from the
// center; from there the point moves one stage on whenever its next stage may load, through
// magnitudes, two normalization stages (which run beside the squared-distance multiply and
// compare), the half-plane fold and one cell per CORDIC step, into the output register where
// the bearing is rounded and checked against the sector. Every stage has its own valid bit, so a
// stalled result only stops the stages that are full, and empty stages upstream keep taking
// points. Configuration writes take effect on the next cycle and should be made while no point
// is in flight.
module point_in_sector_test #(
	parameter int ANGLE_BITS   = pis_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = pis_pkg::CORDIC_STEPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	pis_pt_if.sink                         pt,
	pis_res_if.source                      res,
	input  logic                           cfg_we,
	input  logic [pis_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [pis_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Stage positions in the valid/ready chain.
	localparam int S_CELL0 = 5;
	localparam int L       = CORDIC_STEPS + 6;
	localparam logic [31:0] RND = 32'd1 << (31 - ANGLE_BITS);

	// Configuration registers.
	logic [31:0] center_x_q;
	logic [31:0] center_y_q;
	logic [15:0] heading_q;
	logic [30:0] reach_q;
	logic [15:0] span_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			heading_q  <= '0;
			reach_q    <= pis_pkg::REACH_RST;
			span_q     <= pis_pkg::SPAN_RST;
		end else if (cfg_we) begin
			case (pis_pkg::cfg_idx_t'(cfg_idx))
				pis_pkg::CFG_CENTER_X: center_x_q <= cfg_data;
				pis_pkg::CFG_CENTER_Y: center_y_q <= cfg_data;
				pis_pkg::CFG_HEADING:  heading_q  <= cfg_data[15:0];
				pis_pkg::CFG_REACH:    reach_q    <= cfg_data[30:0];
				pis_pkg::CFG_SPAN:     span_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Per-stage valid bits; a stage loads when it is empty or the stage after it moves.
	logic [L-1:0] v_q;
	logic [L-1:0] rdy;

	always_comb begin
		rdy[L-1] = ~v_q[L-1] | res.ready;
		for (int k = L - 2; k >= 0; k--) begin
			rdy[k] = ~v_q[k] | rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= pt.valid;
			end
			for (int k = 1; k < L; k++) begin
				if (rdy[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign pt.ready  = rdy[0];
	assign res.valid = v_q[L-1];

	// Stage 1: offsets from the center, exact in 33 bits.
	logic signed [32:0] dx_s1;
	logic signed [32:0] dy_s1;

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			dx_s1 <= $signed({pt.point_x[31], pt.point_x}) - $signed({center_x_q[31], center_x_q});
			dy_s1 <= $signed({pt.point_y[31], pt.point_y}) - $signed({center_y_q[31], center_y_q});
		end
	end

	// Stage 2: magnitudes, the radius prefilter and the axis cases.
	logic signed [32:0] dx_s2;
	logic signed [32:0] dy_s2;
	logic [31:0]        adx_s2;
	logic [31:0]        ady_s2;
	logic               pre_s2;
	logic               spec_s2;
	logic [31:0]        spz_s2;
	logic [31:0]        adx;
	logic [31:0]        ady;
	logic [31:0]        spz;

	always_comb begin
		adx = dx_s1[32] ? 32'(-dx_s1) : dx_s1[31:0];
		ady = dy_s1[32] ? 32'(-dy_s1) : dy_s1[31:0];
		if (dy_s1 == '0) begin
			spz = dx_s1[32] ? pis_pkg::TURN_HALF : pis_pkg::TURN_ZERO;
		end else begin
			spz = dy_s1[32] ? pis_pkg::TURN_3Q : pis_pkg::TURN_QUARTER;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			adx_s2  <= adx;
			ady_s2  <= ady;
			pre_s2  <= (adx <= {1'b0, reach_q}) && (ady <= {1'b0, reach_q});
			spec_s2 <= (dx_s1 == '0) || (dy_s1 == '0);
			spz_s2  <= spz;
		end
	end

	// Stage 3: squares for the distance check; first half of normalization.
	pis_pkg::norm_t na_d;
	pis_pkg::norm_t na_s3;
	pis_pkg::norm_t nb_s4;
	logic [61:0]    sqx_s3;
	logic [61:0]    sqy_s3;
	logic [61:0]    rr_s3;
	logic           pre_s3;
	logic           spec_s3;
	logic [31:0]    spz_s3;

	always_comb begin
		na_d.x = pis_pkg::NW'(dx_s2);
		na_d.y = pis_pkg::NW'(dy_s2);
		na_d.w = pis_pkg::MW'(adx_s2 | ady_s2);
	end

	pis_norm #(.SH0(32)) u_norm_a (
		.clk (clk),
		.en  (rdy[2]),
		.d   (na_d),
		.q   (na_s3)
	);

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			sqx_s3  <= adx_s2[30:0] * adx_s2[30:0];
			sqy_s3  <= ady_s2[30:0] * ady_s2[30:0];
			rr_s3   <= reach_q * reach_q;
			pre_s3  <= pre_s2;
			spec_s3 <= spec_s2;
			spz_s3  <= spz_s2;
		end
	end

	// Stage 4: distance compare; second half of normalization.
	logic        within_s4;
	logic        spec_s4;
	logic [31:0] spz_s4;

	pis_norm #(.SH0(4)) u_norm_b (
		.clk (clk),
		.en  (rdy[3]),
		.d   (na_s3),
		.q   (nb_s4)
	);

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			within_s4 <= pre_s3 && (({1'b0, sqx_s3} + {1'b0, sqy_s3}) <= {1'b0, rr_s3});
			spec_s4   <= spec_s3;
			spz_s4    <= spz_s3;
		end
	end

	// Stage 5: fold the left half-plane onto the right one and seed the angle.
	pis_pkg::rot_t rot_d;
	pis_pkg::rot_t rot_s5;
	pis_pkg::rot_t rot [CORDIC_STEPS+1];

	always_comb begin
		rot_d.hold = spec_s4;
		rot_d.near = within_s4;
		rot_d.x    = pis_pkg::CW'(nb_s4.x);
		rot_d.y    = pis_pkg::CW'(nb_s4.y);
		rot_d.z    = pis_pkg::TURN_ZERO;
		if (nb_s4.x[pis_pkg::NW-1]) begin
			rot_d.x = -pis_pkg::CW'(nb_s4.x);
			rot_d.y = -pis_pkg::CW'(nb_s4.y);
			rot_d.z = pis_pkg::TURN_HALF;
		end
		if (spec_s4) begin
			rot_d.z = spz_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			rot_s5 <= rot_d;
		end
	end

	assign rot[0] = rot_s5;

	// CORDIC cell chain, one micro-rotation per cell.
	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
		pis_cell #(.IDX(g)) u_cell (
			.clk (clk),
			.en  (rdy[S_CELL0+g]),
			.d   (rot[g]),
			.q   (rot[g+1])
		);
	end

	// Output stage: round the bearing and test it against the sector bounds.
	logic [31:0]           zr;
	logic [ANGLE_BITS-1:0] b;
	logic [ANGLE_BITS-1:0] h;
	logic [ANGLE_BITS-1:0] half;
	logic [ANGLE_BITS-1:0] ang_lo;
	logic [ANGLE_BITS-1:0] ang_hi;
	logic                  in_range;
	logic                  inside_q;
	logic                  within_q;
	logic [15:0]           bearing_q;

	always_comb begin
		zr     = rot[CORDIC_STEPS].z + RND;
		b      = zr[31 -: ANGLE_BITS];
		h      = ANGLE_BITS'(heading_q);
		half   = ANGLE_BITS'(span_q) >> 1;
		ang_lo = h - half;
		ang_hi = h + half;
		if (ang_lo < ang_hi) begin
			in_range = (ang_lo <= b) && (b <= ang_hi);
		end else begin
			in_range = (ang_lo <= b) || (b <= ang_hi);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[L-1]) begin
			inside_q  <= rot[CORDIC_STEPS].near && in_range;
			within_q  <= rot[CORDIC_STEPS].near;
			bearing_q <= 16'(b);
		end
	end

	assign res.inside_res   = inside_q;
	assign res.within_reach = within_q;
	assign res.bearing      = bearing_q;

`ifndef NO_ASSERTIONS
	// An accepted word always occupies the first stage on the next cycle.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		pt.valid && pt.ready |=> v_q[0])
		else $error("accepted word did not enter the first stage");

	// Input is refused only when every stage of the pipeline is full.
	a_refuse_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pt.ready |-> &v_q)
		else $error("input refused while the pipeline has a free stage");

	// A point inside the sector must also be within reach.
	a_inside_reach: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (!res.inside_res || res.within_reach))
		else $error("inside flagged for a point out of reach");

	// Axis points leave the chain on an exact quarter-turn angle.
	a_axis_exact: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[L-2] && rot[CORDIC_STEPS].hold |-> rot[CORDIC_STEPS].z[29:0] == '0)
		else $error("axis point bearing is not a multiple of a quarter turn");
`endif

endmodule
